[rtl/bchd_pkg.sv]
// Shared types and constants for the button click and hold detector.
package bchd_pkg;

  localparam logic [1:0] OP_PRESS   = 2'd0;
  localparam logic [1:0] OP_RELEASE = 2'd1;
  localparam logic [1:0] OP_SCAN    = 2'd2;

  localparam logic EV_CLICK = 1'b0;
  localparam logic EV_HOLD  = 1'b1;

  localparam logic [7:0]  SAT_UNITS     = 8'hFF;
  localparam logic [15:0] UNIT_RESET_MS = 16'd1000;

  typedef struct packed {
    logic [1:0]  op;
    logic [3:0]  button_index;
    logic [31:0] now_ms;
  } req_t;

  typedef struct packed {
    logic       event_kind;
    logic [3:0] event_button;
    logic [7:0] hold_units;
    logic       last;
  } evt_t;

  typedef struct packed {
    logic       done;
    logic [7:0] quot;
  } div_stat_t;

endpackage

[rtl/bchd_div.sv]
// Shared saturating divider: elapsed ms / unit, clamped to 255, one quotient bit a cycle.
module bchd_div (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [31:0]           dividend,
  input  logic [15:0]           divisor,
  output bchd_pkg::div_stat_t   stat
);
  import bchd_pkg::*;

  logic        running;
  logic        done;
  logic [7:0]  quot;
  logic [23:0] rem;
  logic [22:0] dsr;
  logic [2:0]  cnt;
  logic [24:0] diff;
  logic        sat;

  // quotient reaches 256 or more when dividend >= divisor * 256
  assign sat  = dividend >= {8'b0, divisor, 8'b0};
  assign diff = {1'b0, rem} - {2'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        if (sat) begin
          quot <= SAT_UNITS;
          done <= 1'b1;
        end else begin
          running <= 1'b1;
          rem     <= dividend[23:0];
          dsr     <= {divisor, 7'b0};
          cnt     <= 3'd7;
          quot    <= 8'd0;
        end
      end else if (running) begin
        if (!diff[24]) begin
          rem <= diff[23:0];
        end
        quot <= {quot[6:0], ~diff[24]};
        dsr  <= dsr >> 1;
        cnt  <= cnt - 3'd1;
        if (cnt == 3'd0) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  assign stat.done = done;
  assign stat.quot = quot;

endmodule

[rtl/button_click_hold_detector.sv]
// Top level: per-button press tracking, scan sequencer and event output register.
// Press: block stays ready. Release: unless a hold was reported, a click goes via S_FINAL to the output.
// Timer scan: each button passes S_SCAN and S_NEXT, a held one also S_DIV (8-step divider)
// and perhaps S_PUSH; no new request is taken during a scan or release.
// Each event waits in the output register until taken; stall there holds the sequencer.
// Synchronous reset clears all button flags and counts; hold_unit_ms returns to 1000.
module button_click_hold_detector #(
  parameter int NUM_BUTTONS = 9
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_wr_en,
  input  logic [15:0]      cfg_wr_data,
  input  logic             req_valid,
  output logic             req_stall,
  input  bchd_pkg::req_t   req,
  output logic             evt_valid,
  input  logic             evt_stall,
  output bchd_pkg::evt_t   evt
);
  import bchd_pkg::*;

  localparam int IDX_W = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_BUTTONS - 1);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_SCAN  = 6'b000010,
    S_DIV   = 6'b000100,
    S_PUSH  = 6'b001000,
    S_NEXT  = 6'b010000,
    S_FINAL = 6'b100000
  } state_t;

  state_t state;

  logic [15:0]      hold_unit_ms;
  logic [15:0]      unit_eff;
  logic             pressed [NUM_BUTTONS];
  logic             skip    [NUM_BUTTONS];
  logic [7:0]       held    [NUM_BUTTONS];
  logic [31:0]      ptime   [NUM_BUTTONS];

  logic [IDX_W-1:0] idx;
  logic [31:0]      now_reg;
  logic             have_pend;
  evt_t             pend;
  evt_t             hold_evt;

  logic             accept;
  logic             btn_ok;
  logic [IDX_W-1:0] btn;
  logic             out_free;
  logic             evt_load;
  logic             div_start;
  div_stat_t        div_stat;

  assign unit_eff  = (hold_unit_ms == 16'd0) ? 16'd1 : hold_unit_ms;
  assign req_stall = (state != S_IDLE);
  assign accept    = req_valid && !req_stall;
  assign btn_ok    = 32'(req.button_index) < NUM_BUTTONS;
  assign btn       = IDX_W'(req.button_index);
  assign out_free  = !evt_valid || !evt_stall;
  assign evt_load  = out_free && ((state == S_PUSH) || (state == S_FINAL));
  assign div_start = (state == S_SCAN) && pressed[idx];

  assign hold_evt.event_kind   = EV_HOLD;
  assign hold_evt.event_button = 4'(idx);
  assign hold_evt.hold_units   = div_stat.quot;
  assign hold_evt.last         = 1'b0;

  bchd_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (now_reg - ptime[idx]),
    .divisor  (unit_eff),
    .stat     (div_stat)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_unit_ms <= UNIT_RESET_MS;
    end else if (cfg_wr_en) begin
      hold_unit_ms <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      have_pend <= 1'b0;
      evt_valid <= 1'b0;
      for (int i = 0; i < NUM_BUTTONS; i++) begin
        pressed[i] <= 1'b0;
        skip[i]    <= 1'b0;
        held[i]    <= 8'd0;
      end
    end else begin
      if (evt_load) begin
        evt_valid <= 1'b1;
      end else if (evt_valid && !evt_stall) begin
        evt_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            case (req.op)
              OP_PRESS: begin
                if (btn_ok && !pressed[btn]) begin
                  pressed[btn] <= 1'b1;
                  skip[btn]    <= 1'b0;
                  held[btn]    <= 8'd0;
                  ptime[btn]   <= req.now_ms;
                end
              end
              OP_RELEASE: begin
                if (btn_ok && pressed[btn]) begin
                  pressed[btn] <= 1'b0;
                  skip[btn]    <= 1'b0;
                  if (!skip[btn]) begin
                    pend.event_kind   <= EV_CLICK;
                    pend.event_button <= req.button_index;
                    pend.hold_units   <= 8'd0;
                    pend.last         <= 1'b0;
                    have_pend         <= 1'b1;
                    state             <= S_FINAL;
                  end
                end
              end
              OP_SCAN: begin
                idx     <= '0;
                now_reg <= req.now_ms;
                state   <= S_SCAN;
              end
              default: ;
            endcase
          end
        end
        S_SCAN: begin
          state <= pressed[idx] ? S_DIV : S_NEXT;
        end
        S_DIV: begin
          if (div_stat.done) begin
            if (div_stat.quot > held[idx]) begin
              held[idx] <= div_stat.quot;
              skip[idx] <= 1'b1;
              if (have_pend) begin
                state <= S_PUSH;
              end else begin
                pend      <= hold_evt;
                have_pend <= 1'b1;
                state     <= S_NEXT;
              end
            end else begin
              state <= S_NEXT;
            end
          end
        end
        S_PUSH: begin
          // older event is not the final one; newer takes its place
          if (out_free) begin
            evt       <= pend;
            pend      <= hold_evt;
            state     <= S_NEXT;
          end
        end
        S_NEXT: begin
          if (idx == LAST_IDX) begin
            state <= have_pend ? S_FINAL : S_IDLE;
          end else begin
            idx   <= idx + 1'b1;
            state <= S_SCAN;
          end
        end
        S_FINAL: begin
          if (out_free) begin
            evt.event_kind   <= pend.event_kind;
            evt.event_button <= pend.event_button;
            evt.hold_units   <= pend.hold_units;
            evt.last         <= 1'b1;
            have_pend        <= 1'b0;
            state            <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

[rtl/bchd_checker.sv]
// Port-level checks for the button click and hold detector, bound to the top level.
module bchd_checker (
  input logic             clk,
  input logic             rst,
  input logic             req_valid,
  input logic             req_stall,
  input bchd_pkg::req_t   req,
  input logic             evt_valid,
  input logic             evt_stall,
  input bchd_pkg::evt_t   evt
);
  import bchd_pkg::*;

  a_evt_hold: assert property (@(posedge clk) disable iff (rst)
    evt_valid && evt_stall |=> evt_valid && $stable(evt))
    else $error("stalled event changed or dropped");

  a_scan_busy: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_stall && req.op == OP_SCAN |=> req_stall)
    else $error("ready right after a scan request");

  a_click_shape: assert property (@(posedge clk) disable iff (rst)
    evt_valid && evt.event_kind == EV_CLICK |-> evt.hold_units == 8'd0 && evt.last)
    else $error("click event malformed");

  a_more_pending: assert property (@(posedge clk) disable iff (rst)
    evt_valid && !evt_stall && !evt.last |-> req_stall)
    else $error("ready while events of a scan remain");

  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !evt_valid)
    else $error("event valid after reset");

endmodule

bind button_click_hold_detector bchd_checker u_bchd_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req_valid),
  .req_stall (req_stall),
  .req       (req),
  .evt_valid (evt_valid),
  .evt_stall (evt_stall),
  .evt       (evt)
);
